### design/fwsw_pkg.sv
// Shared types and constants for the event FIFO with stall watchdog.
`default_nettype none
package fwsw_pkg;

    localparam int DEPTH       = 16;
    localparam int EVENT_WIDTH = 32;
    localparam int COUNT_W     = $clog2(DEPTH + 1);
    localparam int LIMIT_W     = 5;
    localparam int THRESH_W    = 16;
    localparam int CFG_DATA_W  = 16;

    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(16);
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(1000);

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_TICK = 2'd2,
        OP_NOP  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_PUSH_FULL  = 2'd1,
        ST_POP_EMPTY  = 2'd2,
        ST_FALSE_DET  = 2'd3
    } t_status;

    typedef enum logic {
        CFG_DEPTH_LIMIT     = 1'b0,
        CFG_STALL_THRESHOLD = 1'b1
    } t_cfg_index;

    typedef struct packed {
        t_opcode                opcode;
        logic [EVENT_WIDTH-1:0] event_word;
    } t_in_item;

    typedef struct packed {
        logic [EVENT_WIDTH-1:0] pop_word;
        logic [EVENT_WIDTH-1:0] head_word;
        logic                   empty_flag;
        logic                   full_flag;
        logic [COUNT_W-1:0]     occupancy;
        logic [COUNT_W-1:0]     free_slots;
        logic [COUNT_W-1:0]     peak_occupancy;
        logic                   stalled;
        logic                   deadlock_seen;
        t_status                status;
    } t_out_item;

    // Per-cycle control shared by every storage cell.
    typedef struct packed {
        logic                   shift;
        logic [EVENT_WIDTH-1:0] load_word;
    } t_cell_ctl;

    // Watchdog outcome for the current transaction.
    typedef struct packed {
        logic stalled;
        logic deadlock;
        logic false_det;
    } t_wd_status;

endpackage
`default_nettype wire

### design/fwsw_cell.sv
// One storage cell of the shifting queue; the head lives in cell zero.
`default_nettype none
module fwsw_cell (
    input  wire logic                            i_clk,
    input  wire fwsw_pkg::t_cell_ctl             i_ctl,
    input  wire logic                            i_load,
    input  wire logic [fwsw_pkg::EVENT_WIDTH-1:0] i_next_word,
    output logic      [fwsw_pkg::EVENT_WIDTH-1:0] o_word
);
    import fwsw_pkg::*;

    logic [EVENT_WIDTH-1:0] r_word;
    logic [EVENT_WIDTH-1:0] n_word;

    always_comb begin
        n_word = r_word;
        if (i_load) begin
            n_word = i_ctl.load_word;
        end else if (i_ctl.shift) begin
            n_word = i_next_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule
`default_nettype wire

### design/fwsw_watchdog.sv
// Stall counter, remembered head and sticky deadlock flag.
`default_nettype none
module fwsw_watchdog #(
    parameter int STALL_WIDTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_tick,
    input  wire logic                             i_step,
    input  wire logic [fwsw_pkg::EVENT_WIDTH-1:0] i_head,
    input  wire logic [fwsw_pkg::THRESH_W-1:0]    i_threshold,
    output fwsw_pkg::t_wd_status                  o_status
);
    import fwsw_pkg::*;

    localparam int CMP_W = (STALL_WIDTH > THRESH_W) ? STALL_WIDTH : THRESH_W;

    logic [STALL_WIDTH-1:0] r_stall;
    logic [STALL_WIDTH-1:0] n_stall;
    logic [EVENT_WIDTH-1:0] r_remembered;
    logic [EVENT_WIDTH-1:0] n_remembered;
    logic                   r_deadlock;
    logic                   n_deadlock;
    logic                   w_over;

    always_comb begin
        n_stall      = r_stall;
        n_remembered = r_remembered;
        o_status.false_det = 1'b0;
        if (i_tick) begin
            if (i_head == r_remembered) begin
                if (!(&r_stall)) begin
                    n_stall = r_stall + STALL_WIDTH'(1);
                end
            end else begin
                o_status.false_det = r_deadlock;
                n_remembered       = i_head;
                n_stall            = '0;
            end
        end
        w_over     = CMP_W'(n_stall) > CMP_W'(i_threshold);
        n_deadlock = r_deadlock | (i_tick & w_over);
        o_status.stalled  = w_over;
        o_status.deadlock = n_deadlock;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stall      <= '0;
            r_remembered <= '0;
            r_deadlock   <= 1'b0;
        end else if (i_step) begin
            r_stall      <= n_stall;
            r_remembered <= n_remembered;
            r_deadlock   <= n_deadlock;
        end
    end

endmodule
`default_nettype wire

### design/fifo_with_stall_watchdog_unit.sv
// A result is loaded into the output register in the cycle after its transaction.
// Throughput: one transaction per cycle while the result is taken; the queue is a
// row of shifting cells that all move together on a pop, and the result register
// frees as it is drained. Reset (synchronous, active low) empties the queue, clears
// occupancy, peak, stall state and deadlock flag, restores the depth limit to 16 and
// threshold to 1000. Queue storage is not cleared; only written cells are ever read.
`default_nettype none
module fifo_with_stall_watchdog_unit #(
    parameter int STALL_WIDTH = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire fwsw_pkg::t_in_item              i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output fwsw_pkg::t_out_item                  o_out_data,
    input  wire logic                            i_cfg_we,
    input  wire fwsw_pkg::t_cfg_index            i_cfg_index,
    input  wire logic [fwsw_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fwsw_pkg::*;

    logic [LIMIT_W-1:0]     r_depth_limit;
    logic [THRESH_W-1:0]    r_threshold;
    logic [COUNT_W-1:0]     r_count;
    logic [COUNT_W-1:0]     n_count;
    logic [COUNT_W-1:0]     r_peak;
    logic [COUNT_W-1:0]     n_peak;
    logic                   r_out_valid;
    t_out_item              r_out;
    t_out_item              n_out;

    logic                   w_step;
    logic [COUNT_W-1:0]     w_limit;
    logic                   w_full_now;
    logic                   w_push;
    logic                   w_pop;
    logic                   w_tick;
    logic                   w_full_next;
    logic [EVENT_WIDTH-1:0] w_head_next;
    t_cell_ctl              w_ctl;
    t_status                w_status;
    t_wd_status             w_wd;
    logic [EVENT_WIDTH-1:0] w_cell [DEPTH];

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_step      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A limit of zero behaves as one; anything past the storage size is clamped.
    always_comb begin
        if (r_depth_limit == '0) begin
            w_limit = COUNT_W'(1);
        end else if (COUNT_W'(r_depth_limit) > COUNT_W'(DEPTH)) begin
            w_limit = COUNT_W'(DEPTH);
        end else begin
            w_limit = COUNT_W'(r_depth_limit);
        end
    end

    always_comb begin
        w_full_now = r_count >= w_limit;
        w_push     = 1'b0;
        w_pop      = 1'b0;
        w_tick     = 1'b0;
        w_status   = ST_OK;
        case (i_in_data.opcode)
            OP_PUSH: begin
                if (w_full_now) begin
                    w_status = ST_PUSH_FULL;
                end else begin
                    w_push = 1'b1;
                end
            end
            OP_POP: begin
                if (r_count == '0) begin
                    w_status = ST_POP_EMPTY;
                end else begin
                    w_pop = 1'b1;
                end
            end
            OP_TICK: begin
                w_tick = r_count != '0;
            end
            default: begin
            end
        endcase
        if (w_wd.false_det) begin
            w_status = ST_FALSE_DET;
        end
    end

    always_comb begin
        w_ctl.shift     = w_step && w_pop;
        w_ctl.load_word = i_in_data.event_word;
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [EVENT_WIDTH-1:0] w_neighbor;
            if (gi == DEPTH - 1) begin : g_last
                assign w_neighbor = w_cell[gi];
            end else begin : g_mid
                assign w_neighbor = w_cell[gi+1];
            end
            fwsw_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_load      (w_step && w_push && (r_count == COUNT_W'(gi))),
                .i_next_word (w_neighbor),
                .o_word      (w_cell[gi])
            );
        end
    endgenerate

    fwsw_watchdog #(
        .STALL_WIDTH (STALL_WIDTH)
    ) u_watchdog (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (w_tick),
        .i_step      (w_step),
        .i_head      (w_cell[0]),
        .i_threshold (r_threshold),
        .o_status    (w_wd)
    );

    always_comb begin
        n_count = r_count;
        if (w_push) begin
            n_count = r_count + COUNT_W'(1);
        end else if (w_pop) begin
            n_count = r_count - COUNT_W'(1);
        end
        n_peak = (n_count > r_peak) ? n_count : r_peak;

        // Head after the transaction: a pop exposes the second cell, a push
        // into an empty queue makes the new word the head.
        if (w_pop) begin
            w_head_next = (DEPTH > 1) ? w_cell[1] : w_cell[0];
        end else if (w_push && (r_count == '0)) begin
            w_head_next = i_in_data.event_word;
        end else begin
            w_head_next = w_cell[0];
        end

        w_full_next          = n_count >= w_limit;
        n_out.pop_word       = w_pop ? w_cell[0] : '0;
        n_out.head_word      = (n_count != '0) ? w_head_next : '0;
        n_out.empty_flag     = n_count == '0;
        n_out.full_flag      = w_full_next;
        n_out.occupancy      = n_count;
        n_out.free_slots     = w_full_next ? '0 : (w_limit - n_count);
        n_out.peak_occupancy = n_peak;
        n_out.stalled        = w_wd.stalled;
        n_out.deadlock_seen  = w_wd.deadlock;
        n_out.status         = w_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_peak      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_step) begin
                r_count     <= n_count;
                r_peak      <= n_peak;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_limit <= LIMIT_RESET;
            r_threshold   <= THRESH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEPTH_LIMIT:     r_depth_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_STALL_THRESHOLD: r_threshold   <= i_cfg_data[THRESH_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### sim/fwsw_checker.sv
// Result predictor and scoreboard for the event FIFO with stall watchdog.
`timescale 1ns / 100ps
module fwsw_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    input  wire logic                            i_in_ready,
    input  wire fwsw_pkg::t_in_item              i_in_data,
    input  wire logic                            i_out_valid,
    input  wire logic                            i_out_ready,
    input  wire fwsw_pkg::t_out_item             i_out_data,
    input  wire logic                            i_cfg_we,
    input  wire fwsw_pkg::t_cfg_index            i_cfg_index,
    input  wire logic [fwsw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                   o_pending,
    output int                                   o_fail_count
);
    import fwsw_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);

    logic [EVENT_WIDTH-1:0] slot_mem [DEPTH];
    logic [PTR_W-1:0]       rd_ptr;
    logic [PTR_W-1:0]       wr_ptr;
    logic [COUNT_W-1:0]     fill;
    logic [COUNT_W-1:0]     peak_fill;
    logic [EVENT_WIDTH-1:0] last_head;
    logic [THRESH_W-1:0]    stall_cnt;
    logic                   deadlock;
    logic [LIMIT_W-1:0]     limit_reg;
    logic [THRESH_W-1:0]    thresh_reg;

    t_out_item due_views [$];
    t_out_item view_now;
    t_out_item view_want;
    int        mismatch_total = 0;

    task automatic note_mismatch(input string what);
        mismatch_total++;
        $display("%0t: mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [EVENT_WIDTH-1:0] got,
                               input logic [EVENT_WIDTH-1:0] want);
        if (got !== want) begin
            note_mismatch($sformatf("%s is %0h, predicted %0h", name, got, want));
        end
    endtask

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    // Applies one transaction to the predicted queue state and returns the view after it.
    task automatic step_event_fifo(input t_in_item item, output t_out_item view);
        logic [COUNT_W-1:0]     lim;
        logic [EVENT_WIDTH-1:0] popped;
        t_status                st;
        if (limit_reg == '0) begin
            lim = COUNT_W'(1);
        end else if (limit_reg > LIMIT_W'(DEPTH)) begin
            lim = COUNT_W'(DEPTH);
        end else begin
            lim = COUNT_W'(limit_reg);
        end
        popped = '0;
        st = ST_OK;
        case (item.opcode)
            OP_PUSH: begin
                if (fill >= lim) begin
                    st = ST_PUSH_FULL;
                end else begin
                    slot_mem[wr_ptr] = item.event_word;
                    wr_ptr = advance(wr_ptr);
                    fill = fill + 1'b1;
                    if (fill > peak_fill) peak_fill = fill;
                end
            end
            OP_POP: begin
                if (fill == '0) begin
                    st = ST_POP_EMPTY;
                end else begin
                    popped = slot_mem[rd_ptr];
                    rd_ptr = advance(rd_ptr);
                    fill = fill - 1'b1;
                end
            end
            OP_TICK: begin
                if (fill != '0) begin
                    if (slot_mem[rd_ptr] == last_head) begin
                        if (stall_cnt != '1) stall_cnt = stall_cnt + 1'b1;
                    end else begin
                        if (deadlock) st = ST_FALSE_DET;
                        last_head = slot_mem[rd_ptr];
                        stall_cnt = '0;
                    end
                    if (stall_cnt > thresh_reg) deadlock = 1'b1;
                end
            end
            default: begin
            end
        endcase
        view.pop_word       = popped;
        view.head_word      = (fill != '0) ? slot_mem[rd_ptr] : '0;
        view.empty_flag     = (fill == '0);
        view.full_flag      = (fill >= lim);
        view.occupancy      = fill;
        view.free_slots     = (fill >= lim) ? '0 : lim - fill;
        view.peak_occupancy = peak_fill;
        view.stalled        = (stall_cnt > thresh_reg);
        view.deadlock_seen  = deadlock;
        view.status         = st;
    endtask

    task automatic compare_view(input t_out_item got, input t_out_item want);
        check_field("pop_word", got.pop_word, want.pop_word);
        check_field("head_word", got.head_word, want.head_word);
        check_field("empty_flag", got.empty_flag, want.empty_flag);
        check_field("full_flag", got.full_flag, want.full_flag);
        check_field("occupancy", got.occupancy, want.occupancy);
        check_field("free_slots", got.free_slots, want.free_slots);
        check_field("peak_occupancy", got.peak_occupancy, want.peak_occupancy);
        check_field("stalled", got.stalled, want.stalled);
        check_field("deadlock_seen", got.deadlock_seen, want.deadlock_seen);
        check_field("status", got.status, want.status);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd_ptr     = '0;
            wr_ptr     = '0;
            fill       = '0;
            peak_fill  = '0;
            last_head  = '0;
            stall_cnt  = '0;
            deadlock   = 1'b0;
            limit_reg  = LIMIT_RESET;
            thresh_reg = THRESH_RESET;
            due_views.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (due_views.size() == 0) begin
                    note_mismatch("result transaction with no prediction waiting");
                end else begin
                    view_want = due_views.pop_front();
                    compare_view(i_out_data, view_want);
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_DEPTH_LIMIT) begin
                    limit_reg = i_cfg_data[LIMIT_W-1:0];
                end else begin
                    thresh_reg = i_cfg_data[THRESH_W-1:0];
                end
            end
            if (i_in_valid && i_in_ready) begin
                step_event_fifo(i_in_data, view_now);
                due_views.push_back(view_now);
            end
        end
        o_pending    <= due_views.size();
        o_fail_count <= mismatch_total;
    end

endmodule

### sim/testbench.sv
// Stimulus and verdict for the event FIFO with stall watchdog.
`timescale 1ns / 100ps
module testbench;
    import fwsw_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_ITEMS  = 240;
    localparam int PHASES       = 7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_item              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_data;
    logic                  cfg_we = 1'b0;
    t_cfg_index            cfg_index = CFG_DEPTH_LIMIT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int                     pending;
    int                     fail_count;
    int                     cycle_count = 0;
    int                     ready_run = 0;
    int                     ready_roll;
    bit                     calm = 1'b0;
    logic [EVENT_WIDTH-1:0] last_word = '0;

    int limit_plan [PHASES]  = '{16, 1, 5, 31, 2, 0, 9};
    int thresh_plan [PHASES] = '{3, 0, 10, 65535, 1, 2, 6};

    fifo_with_stall_watchdog_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    fwsw_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("fifo_with_stall_watchdog_unit regression: fail");
            $finish;
        end
    end

    // Result side backpressure: runs of ready and stall, mostly short.
    always @(posedge i_clk) begin
        if (ready_run != 0) begin
            ready_run <= ready_run - 1;
        end else if (calm) begin
            out_ready <= 1'b1;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 70) begin
                out_ready <= 1'b1;
                ready_run <= $urandom_range(0, 6);
            end else if (ready_roll < 95) begin
                out_ready <= 1'b0;
                ready_run <= $urandom_range(0, 3);
            end else begin
                out_ready <= 1'b0;
                ready_run <= $urandom_range(10, 40);
            end
        end
    end

    function automatic int draw_gap();
        int roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [EVENT_WIDTH-1:0] pick_word();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        // Repeating a word lets a new head equal the remembered one.
        if (roll == 2) return last_word;
        return $urandom;
    endfunction

    task automatic issue_op(input t_opcode op, input logic [EVENT_WIDTH-1:0] word);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{opcode: op, event_word: word};
        if (op == OP_PUSH) last_word = word;
        do @(posedge i_clk); while (!in_ready);
    endtask

    // Stop sending and let every predicted result drain before touching registers.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(input int n_items, input int thresh);
        int      sent;
        int      kind;
        int      len;
        t_opcode op;
        sent = 0;
        while (sent < n_items) begin
            calm = ($urandom_range(0, 7) == 0);
            kind = $urandom_range(0, 9);
            len  = $urandom_range(1, 12);
            if (kind >= 5 && kind <= 7) begin
                // Tick runs long enough to cross small thresholds.
                len = $urandom_range(1, (thresh < 20) ? thresh + 4 : 24);
            end
            repeat (len) begin
                case (kind)
                    0, 1, 2: op = OP_PUSH;
                    3, 4:    op = OP_POP;
                    5, 6, 7: op = OP_TICK;
                    default: op = t_opcode'($urandom_range(0, 3));
                endcase
                issue_op(op, pick_word());
                if (op != OP_NOP) sent++;
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: empty-queue cases, unused opcode, first tick on a zero head.
        issue_op(OP_POP, 32'h0);
        issue_op(OP_TICK, 32'h0);
        issue_op(OP_NOP, '1);
        issue_op(OP_PUSH, 32'h0);
        issue_op(OP_TICK, 32'h0);
        issue_op(OP_PUSH, '1);
        issue_op(OP_POP, 32'h0);
        issue_op(OP_TICK, 32'h0);
        issue_op(OP_POP, 32'h0);
        wait_idle();

        // Zero limit acts as one entry; zero threshold trips on the first stall.
        write_reg(CFG_DEPTH_LIMIT, 0);
        write_reg(CFG_STALL_THRESHOLD, 0);
        issue_op(OP_PUSH, 32'h1234_5678);
        issue_op(OP_PUSH, 32'hDEAD_BEEF);
        issue_op(OP_TICK, 32'h0);
        issue_op(OP_TICK, 32'h0);
        issue_op(OP_POP, 32'h0);
        issue_op(OP_PUSH, 32'h5555_AAAA);
        issue_op(OP_TICK, 32'h0);
        issue_op(OP_POP, 32'h0);
        wait_idle();

        // Lower the limit below the current occupancy.
        write_reg(CFG_DEPTH_LIMIT, 16);
        repeat (6) issue_op(OP_PUSH, $urandom);
        wait_idle();
        write_reg(CFG_DEPTH_LIMIT, 4);
        issue_op(OP_PUSH, 32'hAAAA_5555);
        issue_op(OP_POP, 32'h0);
        issue_op(OP_POP, 32'h0);
        issue_op(OP_POP, 32'h0);
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            write_reg(CFG_DEPTH_LIMIT, limit_plan[p]);
            write_reg(CFG_STALL_THRESHOLD, thresh_plan[p]);
            run_phase(PHASE_ITEMS, thresh_plan[p]);
            wait_idle();
        end

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("fifo_with_stall_watchdog_unit regression: pass");
        end else begin
            $display("fifo_with_stall_watchdog_unit regression: fail");
        end
        $finish;
    end

endmodule
